// ----- sv/aps_pkg.sv -----
// ============================================================================
// aps_pkg
// Shared types and constants of the approximate pattern search block.
// ============================================================================
package aps_pkg;

    // Field widths of the input and result words.
    localparam int MODE_W   = 2;
    localparam int POS_W    = 7;
    localparam int SYM_W    = 8;
    localparam int ENDPOS_W = 32;
    localparam int SCORE_W  = 8;

    // Configuration port.
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_W = 2;

    // Input word modes.
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;

    // Register indexes (byte address is four times the index).
    localparam logic [REG_IDX_W-1:0] REG_ERROR_LIMIT    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_USE_CUTOFF     = 2'd2;

    typedef struct packed {
        logic [7:0] error_limit;
        logic [7:0] pattern_length;
        logic       use_cutoff;
    } cfg_t;

endpackage

// ----- sv/aps_intf.sv -----
// ============================================================================
// aps_in_if / aps_out_if
// Valid/ready channels for input words and result words.
// ============================================================================
interface aps_in_if;
    logic                       valid;
    logic                       ready;
    logic [aps_pkg::MODE_W-1:0] mode;
    logic [aps_pkg::POS_W-1:0]  position;
    logic [aps_pkg::SYM_W-1:0]  symbol;

    modport source (output valid, output mode, output position, output symbol,
                    input ready);
    modport sink   (input valid, input mode, input position, input symbol,
                    output ready);
endinterface

interface aps_out_if;
    logic                         valid;
    logic                         ready;
    logic [aps_pkg::ENDPOS_W-1:0] end_position;
    logic [aps_pkg::SCORE_W-1:0]  score;

    modport source (output valid, output end_position, output score, input ready);
    modport sink   (input valid, input end_position, input score, output ready);
endinterface

// ----- sv/aps_ram.sv -----
// ============================================================================
// aps_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module aps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/aps_cfg.sv -----
// ============================================================================
// aps_cfg
// APB register file holding error limit, pattern length and cutoff enable.
// ============================================================================
module aps_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aps_pkg::APB_AW-1:0]  paddr,
    input  logic [aps_pkg::APB_DW-1:0]  pwdata,
    output logic [aps_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output aps_pkg::cfg_t               cfg
);
    import aps_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ERROR_LIMIT:    cfg_next.error_limit    = pwdata[7:0];
                REG_PATTERN_LENGTH: cfg_next.pattern_length = pwdata[7:0];
                REG_USE_CUTOFF:     cfg_next.use_cutoff     = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ERROR_LIMIT:    prdata = APB_DW'(cfg_reg.error_limit);
            REG_PATTERN_LENGTH: prdata = APB_DW'(cfg_reg.pattern_length);
            REG_USE_CUTOFF:     prdata = APB_DW'(cfg_reg.use_cutoff);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.error_limit    <= 8'd0;
            cfg_reg.pattern_length <= 8'd1;
            cfg_reg.use_cutoff     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/approximate_pattern_search.sv -----
// ============================================================================
// approximate_pattern_search
// Edit-distance search of a stored pattern over a streamed text. Input words
// arrive on in_ch: mode load writes one pattern byte, mode restart clears the
// score column and the position counter, mode text scans one text byte. A
// text byte whose bottom-row score is within error_limit yields one word on
// out_ch carrying the 1-based end position and the score. Registers sit on
// the APB port (error_limit at 0x0, pattern_length at 0x4, use_cutoff at 0x8).
// Load and restart words are handled in the idle state. A text word walks L
// column cells, where L is pattern_length, or the last active cell under
// cutoff: the column RAM does one read-modify-write per cycle. The finish
// state after the last cell loads the result. A finished result
// waits in an output register, so new words are accepted while out_ch stalls;
// only a second hit holds the engine until the register drains. Reset is
// immediate: a fill count marks the deepest row written since the last
// restart, every row below it reads as its row index, and the position
// counter is zero. Pattern bytes stay undefined until loaded.
// ============================================================================
module approximate_pattern_search #(
    parameter int MAX_PATTERN = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aps_pkg::APB_AW-1:0]  paddr,
    input  logic [aps_pkg::APB_DW-1:0]  pwdata,
    output logic [aps_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    aps_in_if.sink                      in_ch,
    aps_out_if.source                   out_ch
);
    import aps_pkg::*;

    // Column cells are addressed by row 1..MAX_PATTERN; cell 0 is always zero
    // and never stored. A cell never exceeds its row index, so the cell width
    // equals the address width.
    localparam int CAW = $clog2(MAX_PATTERN + 1);
    localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW  = (CAW > 9) ? CAW : 9;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    cfg_t cfg;

    aps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [1:0]            state_reg, state_next;
    logic [SYM_W-1:0]      sym_reg, sym_next;
    logic [CAW-1:0]        limit_reg, limit_next;
    logic [CAW-1:0]        cmp_j_reg, cmp_j_next;
    logic [CAW-1:0]        diag_reg, diag_next;
    logic [CAW-1:0]        up_reg, up_next;
    logic [CAW-1:0]        best_reg, best_next;
    logic [CAW-1:0]        last_cur_reg, last_cur_next;
    logic [CAW-1:0]        last_active_reg, last_active_next;
    logic [ENDPOS_W-1:0]   text_pos_reg, text_pos_next;
    logic [CAW-1:0]        col_fill_reg, col_fill_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ENDPOS_W-1:0]   end_pos_reg, end_pos_next;
    logic [SCORE_W-1:0]    score_reg, score_next;

    // Memory ports.
    logic                  pat_we;
    logic [PAW-1:0]        pat_waddr, pat_raddr;
    logic [SYM_W-1:0]      pat_rdata;
    logic                  col_we;
    logic [CAW-1:0]        col_raddr;
    logic [CAW-1:0]        col_rdata;

    // Effective configuration.
    logic [LW-1:0]         plen_w, m_w, k_w, start_w;
    logic [CAW-1:0]        m;
    logic [CAW-1:0]        restart_la;
    logic [CAW-1:0]        la_clamped;

    // Cell update.
    logic [CAW-1:0]        left;
    logic [CAW-1:0]        min_ud, min3, cur;
    logic                  sym_match;
    logic                  cur_in_limit;

    logic                  in_acc;
    logic                  hit_cut, hit_full, hit, slot_free;

    aps_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_PATTERN)
    ) u_pattern_ram (
        .clk     (clk),
        .wr_en   (pat_we),
        .wr_addr (pat_waddr),
        .wr_data (in_ch.symbol),
        .rd_addr (pat_raddr),
        .rd_data (pat_rdata)
    );

    aps_ram #(
        .WIDTH (CAW),
        .DEPTH (MAX_PATTERN + 1)
    ) u_column_ram (
        .clk     (clk),
        .wr_en   (col_we),
        .wr_addr (cmp_j_reg),
        .wr_data (cur),
        .rd_addr (col_raddr),
        .rd_data (col_rdata)
    );

    // The pattern length is clamped into 1..MAX_PATTERN before any use.
    always_comb
    begin
        plen_w = LW'(cfg.pattern_length);
        if (plen_w == '0)
        begin
            m_w = LW'(1);
        end
        else if (plen_w > LW'(MAX_PATTERN))
        begin
            m_w = LW'(MAX_PATTERN);
        end
        else
        begin
            m_w = plen_w;
        end
        m          = CAW'(m_w);
        k_w        = LW'(cfg.error_limit);
        start_w    = k_w + LW'(1);
        restart_la = (start_w < m_w) ? CAW'(start_w) : m;
        la_clamped = (last_active_reg > m) ? m : last_active_reg;
    end

    // One column cell per cycle. Every walk starts at row one and runs
    // without gaps, so the rows written since the last restart form a prefix
    // up to the fill count; a row beyond it reads as its own row index.
    always_comb
    begin
        left         = (cmp_j_reg <= col_fill_reg) ? col_rdata : cmp_j_reg;
        sym_match    = (pat_rdata == sym_reg);
        min_ud       = (up_reg < diag_reg) ? up_reg : diag_reg;
        min3         = (left < min_ud) ? left : min_ud;
        cur          = sym_match ? diag_reg : (min3 + CAW'(1));
        cur_in_limit = (LW'(cur) <= k_w);
    end

    assign in_acc       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE);

    assign pat_we    = in_acc && (in_ch.mode == MODE_LOAD)
                       && (LW'(in_ch.position) < LW'(MAX_PATTERN));
    assign pat_waddr = PAW'(in_ch.position);

    // Reads run one cell ahead of the write. Within a scan the write of cell
    // j and the read of cell j + 1 never collide, and the next scan starts
    // its first read only after the previous scan's last write has landed.
    assign pat_raddr = (state_reg == ST_IDLE) ? '0 : PAW'(cmp_j_reg);
    assign col_raddr = (state_reg == ST_IDLE) ? CAW'(1) : (cmp_j_reg + CAW'(1));
    assign col_we    = (state_reg == ST_SCAN);

    // End of a scan. Under cutoff the new last active cell is the row after the
    // deepest cell within the limit (row m on a hit), tracked during the walk,
    // so no downward pass is needed.
    assign hit_cut   = (best_reg == m);
    assign hit_full  = (LW'(last_cur_reg) <= k_w);
    assign hit       = cfg.use_cutoff ? hit_cut : hit_full;
    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next       = state_reg;
        sym_next         = sym_reg;
        limit_next       = limit_reg;
        cmp_j_next       = cmp_j_reg;
        diag_next        = diag_reg;
        up_next          = up_reg;
        best_next        = best_reg;
        last_cur_next    = last_cur_reg;
        last_active_next = last_active_reg;
        text_pos_next    = text_pos_reg;
        col_fill_next    = col_fill_reg;
        out_valid_next   = out_valid_reg;
        end_pos_next     = end_pos_reg;
        score_next       = score_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_ch.mode == MODE_RESTART))
                begin
                    col_fill_next    = '0;
                    last_active_next = restart_la;
                    text_pos_next    = '0;
                end
                else if (in_acc && (in_ch.mode == MODE_TEXT))
                begin
                    sym_next      = in_ch.symbol;
                    limit_next    = cfg.use_cutoff ? la_clamped : m;
                    cmp_j_next    = CAW'(1);
                    diag_next     = '0;
                    up_next       = '0;
                    best_next     = '0;
                    text_pos_next = text_pos_reg + ENDPOS_W'(1);
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmp_j_reg > col_fill_reg)
                begin
                    col_fill_next = cmp_j_reg;
                end
                diag_next = left;
                up_next   = cur;
                if (cur_in_limit)
                begin
                    best_next = cmp_j_reg;
                end
                if (cmp_j_reg == limit_reg)
                begin
                    last_cur_next = cur;
                    state_next    = ST_FIN;
                end
                else
                begin
                    cmp_j_next = cmp_j_reg + CAW'(1);
                end
            end
            ST_FIN:
            begin
                if (!hit || slot_free)
                begin
                    if (cfg.use_cutoff)
                    begin
                        last_active_next = hit_cut ? m : (best_reg + CAW'(1));
                    end
                    if (hit)
                    begin
                        out_valid_next = 1'b1;
                        end_pos_next   = text_pos_reg;
                        score_next     = SCORE_W'(last_cur_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_active_reg <= CAW'(1);
            text_pos_reg    <= '0;
            col_fill_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_active_reg <= last_active_next;
            text_pos_reg    <= text_pos_next;
            col_fill_reg    <= col_fill_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        limit_reg    <= limit_next;
        cmp_j_reg    <= cmp_j_next;
        diag_reg     <= diag_next;
        up_reg       <= up_next;
        best_reg     <= best_next;
        last_cur_reg <= last_cur_next;
        end_pos_reg  <= end_pos_next;
        score_reg    <= score_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.end_position = end_pos_reg;
    assign out_ch.score        = score_reg;

`ifndef SYNTHESIS
    // The walk stays inside rows 1..limit.
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cmp_j_reg != '0) && (cmp_j_reg <= limit_reg))
        else $error("column walk left its row range");

    // A cell never exceeds its row index.
    a_cell_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cur <= cmp_j_reg))
        else $error("column cell exceeds its row index");

    // The last active cell is never row zero.
    a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
        (last_active_reg != '0))
        else $error("last active cell is zero");

    // A text word starts its walk at row one in the next cycle.
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_ch.mode == MODE_TEXT))
        |=> (state_reg == ST_SCAN) && (cmp_j_reg == CAW'(1)))
        else $error("text word did not start a walk");

    // A result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> (out_valid_reg && $stable(end_pos_reg)))
        else $error("pending result overwritten");
`endif

endmodule

// ----- verif/aps_tb_pkg.sv -----
// ============================================================================
// aps_tb_pkg
// Match scoreboard for the approximate pattern search testbench. It keeps its
// own copy of the pattern, the score column and the registers, and works out
// which text words must report a match and with which position and score.
// ============================================================================
package aps_tb_pkg;

    import aps_pkg::*;

    localparam int PATTERN_DEPTH = 128;

    // The fourth mode value has no meaning and is ignored by the block.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [ENDPOS_W-1:0] end_position;
        logic [SCORE_W-1:0]  score;
    } hit_t;

    class match_scoreboard;

        logic [7:0]          error_limit;
        logic [7:0]          pattern_length;
        logic                use_cutoff;
        logic [SYM_W-1:0]    pattern_mem [PATTERN_DEPTH];
        bit                  pattern_loaded [PATTERN_DEPTH];
        int unsigned         column [PATTERN_DEPTH + 1];
        int unsigned         last_active;
        logic [ENDPOS_W-1:0] text_count;
        hit_t                hits_due [$];
        int unsigned         fail_count;
        int unsigned         hits_checked;

        function new();
            error_limit    = 8'd0;
            pattern_length = 8'd1;
            use_cutoff     = 1'b1;
            fail_count     = 0;
            hits_checked   = 0;
            foreach (pattern_loaded[i])
            begin
                pattern_loaded[i] = 1'b0;
                pattern_mem[i]    = '0;
            end
            restart_scan();
        endfunction

        // Pattern length in use, held within 1..PATTERN_DEPTH.
        function int unsigned span();
            int unsigned m;
            m = pattern_length;
            if (m < 1)
                m = 1;
            if (m > PATTERN_DEPTH)
                m = PATTERN_DEPTH;
            return m;
        endfunction

        function void restart_scan();
            int unsigned first_limit;
            first_limit = error_limit + 32'd1;
            foreach (column[j])
                column[j] = j;
            last_active = (first_limit < span()) ? first_limit : span();
            text_count  = '0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_ERROR_LIMIT:    error_limit    = value[7:0];
                REG_PATTERN_LENGTH: pattern_length = value[7:0];
                REG_USE_CUTOFF:     use_cutoff     = value[0];
                default: ;
            endcase
        endfunction

        // Appends one expected match report at the tail of the queue.
        function void expect_hit(int unsigned m);
            hit_t due;
            due.end_position = text_count;
            due.score        = SCORE_W'(column[m]);
            hits_due.insert(hits_due.size(), due);
        endfunction

        // One text byte against rows 1..limit of the column.
        function void walk_column(int unsigned limit, logic [SYM_W-1:0] c);
            int unsigned diag;
            int unsigned up;
            int unsigned cur;
            int unsigned left;
            diag = 0;
            up   = 0;
            for (int unsigned j = 1; j <= limit; j++)
            begin
                left = column[j];
                if (pattern_mem[j - 1] == c)
                    cur = diag;
                else
                begin
                    cur = up;
                    if (diag < cur)
                        cur = diag;
                    if (left < cur)
                        cur = left;
                    cur = cur + 1;
                end
                diag      = left;
                up        = cur;
                column[j] = cur;
            end
        endfunction

        function void scan_text(logic [SYM_W-1:0] c);
            int unsigned m;
            int unsigned lact;
            m          = span();
            text_count = text_count + 1'b1;
            if (use_cutoff)
            begin
                lact = (last_active > m) ? m : last_active;
                walk_column(lact, c);
                while (lact > 0 && column[lact] > error_limit)
                    lact--;
                if (lact == m)
                begin
                    last_active = lact;
                    expect_hit(m);
                end
                else
                    last_active = lact + 1;
            end
            else
            begin
                walk_column(m, c);
                if (column[m] <= error_limit)
                    expect_hit(m);
            end
        endfunction

        function void note_word(logic [MODE_W-1:0] mode, logic [POS_W-1:0] position,
                                logic [SYM_W-1:0] symbol);
            case (mode)
                MODE_LOAD:
                begin
                    pattern_mem[position]    = symbol;
                    pattern_loaded[position] = 1'b1;
                end
                MODE_RESTART: restart_scan();
                MODE_TEXT:    scan_text(symbol);
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return hits_due.size();
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            fail_count++;
        endtask

        task check_hit(logic [ENDPOS_W-1:0] end_position, logic [SCORE_W-1:0] score);
            hit_t due;
            if (hits_due.size() == 0)
            begin
                report($sformatf("unexpected word end_position=%0d score=%0d",
                                 end_position, score));
                return;
            end
            due = hits_due.pop_front();
            hits_checked++;
            if (end_position !== due.end_position)
                report($sformatf("end_position %0d, expected %0d",
                                 end_position, due.end_position));
            if (score !== due.score)
                report($sformatf("score %0d at end_position %0d, expected %0d",
                                 score, due.end_position, due.score));
        endtask

    endclass

endpackage

// ----- verif/tb_top.sv -----
// ============================================================================
// tb_top
// Testbench of approximate_pattern_search. Input words are driven on a
// valid/ready channel and result words are drained with random stalls; every
// accepted input word is fed to a scoreboard that predicts the match reports,
// and every result word is compared field by field with the oldest one due.
// ============================================================================
module tb_top;

    import aps_pkg::*;
    import aps_tb_pkg::*;

    // The slowest correct run stays far below this: about 800 words, each with
    // a full column walk at most, plus random sender and receiver gaps.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // A text word that causes no result may still be in the engine when the
    // last expected word has come; the drain lets a full column walk finish.
    localparam int DRAIN_CYCLES = 140;
    localparam int RANDOM_WORDS = 750;
    localparam int LONG_HOLD    = 400;

    // One stretch of traffic under a single register setting.
    typedef struct {
        logic [7:0] error_limit;
        logic [7:0] pattern_length;
        logic       use_cutoff;
        bit         fresh_pattern;  // load a new pattern over the used rows
        bit         restart;        // restart the scan before the text
        bit         long_hold;      // receiver holds off for a long stretch
        bit         mid_drain;      // sender pauses halfway until all words came
        bit         idle;           // random gaps on both sides
        int         text_words;
    } phase_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    aps_in_if  in_ch ();
    aps_out_if out_ch ();

    approximate_pattern_search dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    match_scoreboard sb;

    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          rx_hold_req;
    int unsigned words_sent;
    int unsigned phases_run;
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run ends here if the block stops answering.
    initial
    begin : watchdog
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Cycle limit of %0d reached with %0d words still due.",
                         CYCLE_LIMIT, sb.pending());
                $display("** approximate_pattern_search: FAILED **");
                $finish;
            end
        end
    end

    // Most gaps are zero or short; now and then a long one.
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side. Words are checked at the edge where valid and ready are
    // both high. A long hold, when asked for, is counted down here so that
    // the sender keeps offering words meanwhile and the block backs up.
    initial
    begin : result_sink
        int unsigned rx_hold;
        int unsigned rx_gap;
        rx_hold = 0;
        rx_gap  = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_hit(out_ch.end_position, out_ch.score);
            if (rx_hold_req)
            begin
                rx_hold     = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ch.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                rx_gap = pick_gap(rx_idle_on);
            end
        end
    end

    // Offers one word and returns right after the edge that accepted it. With
    // no gap, valid stays high so that the next call only changes the payload.
    task automatic send_word(input logic [MODE_W-1:0] mode,
                             input logic [POS_W-1:0]  position,
                             input logic [SYM_W-1:0]  symbol);
        int gap;
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= mode;
        in_ch.position <= position;
        in_ch.symbol   <= symbol;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_word(mode, position, symbol);
        if (mode != MODE_UNUSED)
            words_sent++;
        gap = pick_gap(tx_idle_on);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lowers valid, waits for every predicted word, then lets the engine
    // finish any text word that reports nothing.
    task automatic wait_for_idle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value
    // at the edge where psel, penable, pwrite and pready are all high. The bus
    // then goes idle before the next transfer.
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DW-1:0]    value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic phase_t make_phase(logic [7:0] error_limit, logic [7:0] pattern_length,
                                          logic use_cutoff, bit fresh_pattern, bit restart,
                                          bit long_hold, bit mid_drain, int text_words);
        phase_t ph;
        ph.error_limit    = error_limit;
        ph.pattern_length = pattern_length;
        ph.use_cutoff     = use_cutoff;
        ph.fresh_pattern  = fresh_pattern;
        ph.restart        = restart;
        ph.long_hold      = long_hold;
        ph.mid_drain      = mid_drain;
        ph.idle           = 1'b1;
        ph.text_words     = text_words;
        return ph;
    endfunction

    // One phase: registers are written while the block is idle, the used
    // pattern rows are loaded, and then a text stream follows. Most text is
    // copied from the pattern with substitutions, insertions and deletions so
    // that matches within the error limit actually occur; a few words are
    // noise: ignored words, stray loads and restarts.
    task automatic run_phase(input phase_t ph);
        int unsigned      m;
        int unsigned      tp;
        int               r;
        logic [SYM_W-1:0] letters [4];
        logic [SYM_W-1:0] c;
        wait_for_idle();
        tx_idle_on = ph.idle;
        rx_idle_on = ph.idle;
        write_register(REG_ERROR_LIMIT,    APB_DW'(ph.error_limit));
        write_register(REG_PATTERN_LENGTH, APB_DW'(ph.pattern_length));
        write_register(REG_USE_CUTOFF,     APB_DW'(ph.use_cutoff));
        m = sb.span();
        foreach (letters[i])
            letters[i] = SYM_W'($urandom_range(0, 255));

        // A row that the column walk reads must hold a loaded byte; when the
        // pattern is kept, only rows never loaded so far are filled in.
        for (int unsigned j = 0; j < m; j++)
        begin
            if (ph.fresh_pattern || !sb.pattern_loaded[j])
            begin
                if ($urandom_range(0, 7) == 0)
                    c = SYM_W'($urandom_range(0, 255));
                else
                    c = letters[$urandom_range(0, 3)];
                send_word(MODE_LOAD, POS_W'(j), c);
            end
        end
        if (ph.restart)
            send_word(MODE_RESTART, POS_W'($urandom_range(0, 127)),
                      SYM_W'($urandom_range(0, 255)));
        if (ph.long_hold)
            rx_hold_req = 1'b1;

        tp = 0;
        for (int i = 0; i < ph.text_words; i++)
        begin
            if (ph.mid_drain && i == ph.text_words / 2)
                wait_for_idle();
            r = $urandom_range(0, 99);
            if (r < 3)
                send_word(MODE_UNUSED, POS_W'($urandom_range(0, 127)),
                          SYM_W'($urandom_range(0, 255)));
            else if (r < 6)
                send_word(MODE_LOAD, POS_W'($urandom_range(0, 127)),
                          SYM_W'($urandom_range(0, 255)));
            else if (r < 8)
            begin
                send_word(MODE_RESTART, POS_W'($urandom_range(0, 127)),
                          SYM_W'($urandom_range(0, 255)));
                tp = 0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                // Skipping a pattern byte models a deletion in the text.
                if (r < 8)
                    tp = (tp + 1) % m;
                if (r < 80)
                begin
                    c  = sb.pattern_mem[tp];
                    tp = (tp + 1) % m;
                end
                else if (r < 92)
                    c = letters[$urandom_range(0, 3)];
                else
                    c = SYM_W'($urandom_range(0, 255));
                send_word(MODE_TEXT, POS_W'($urandom_range(0, 127)), c);
            end
        end
        phases_run++;
    endtask

    initial
    begin : stimulus
        phase_t ph;
        sb          = new();
        words_sent  = 0;
        phases_run  = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rx_hold_req = 1'b0;

        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.mode     <= MODE_LOAD;
        in_ch.position <= '0;
        in_ch.symbol   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset settings: error limit zero, one
        // pattern byte, cutoff on. The first text words run on the column as
        // reset left it, without any restart.
        send_word(MODE_UNUSED,  7'd127, 8'hFF);
        send_word(MODE_LOAD,    7'd0,   8'hA5);
        send_word(MODE_LOAD,    7'd127, 8'h00);
        send_word(MODE_TEXT,    7'd0,   8'hA5);
        send_word(MODE_TEXT,    7'd127, 8'h00);
        send_word(MODE_TEXT,    7'd0,   8'hFF);
        send_word(MODE_RESTART, 7'd127, 8'hFF);
        send_word(MODE_TEXT,    7'd0,   8'hA5);
        send_word(MODE_UNUSED,  7'd0,   8'h00);
        send_word(MODE_TEXT,    7'd127, 8'hA5);
        send_word(MODE_LOAD,    7'd0,   8'h00);
        send_word(MODE_TEXT,    7'd0,   8'h00);
        send_word(MODE_TEXT,    7'd0,   8'hFF);

        // Register extremes. An error limit at or above the pattern length
        // makes every text word a match, which fills the result path while
        // the receiver holds off. Lengths of zero and above the maximum are
        // clamped. The last two phases change the setting without a restart,
        // so the kept column and last active cell are reused; the second of
        // them shrinks the pattern below the last active cell.
        run_phase(make_phase(8'd1,   8'd4,   1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 30));
        run_phase(make_phase(8'd10,  8'd4,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 40));
        run_phase(make_phase(8'd0,   8'd128, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 30));
        run_phase(make_phase(8'd128, 8'd128, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 20));
        run_phase(make_phase(8'd255, 8'd0,   1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 30));
        run_phase(make_phase(8'd3,   8'd200, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 20));
        run_phase(make_phase(8'd2,   8'd8,   1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 40));
        run_phase(make_phase(8'd4,   8'd12,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 40));
        run_phase(make_phase(8'd1,   8'd6,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 40));

        // Random settings, mostly short patterns and small limits so that
        // matches are frequent and the column walks stay short.
        while (words_sent < RANDOM_WORDS + 13)
        begin
            ph.error_limit    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'($urandom_range(0, 6));
            ph.pattern_length = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(17, 128))
                                                            : 8'($urandom_range(1, 16));
            ph.use_cutoff     = 1'($urandom_range(0, 1));
            ph.fresh_pattern  = ($urandom_range(0, 4) != 0);
            ph.restart        = ph.fresh_pattern || ($urandom_range(0, 1) == 1);
            ph.long_hold      = ($urandom_range(0, 14) == 0);
            ph.mid_drain      = ($urandom_range(0, 9) == 0);
            ph.idle           = ($urandom_range(0, 4) != 0);
            ph.text_words     = $urandom_range(20, 50);
            run_phase(ph);
        end

        wait_for_idle();
        $display("Covered %0d words over %0d register settings; %0d match reports checked,",
                 words_sent, phases_run, sb.hits_checked);
        $display("with and without cutoff, pattern lengths 1 to 128, limits 0 to 255.");
        if (sb.fail_count == 0)
            $display("** approximate_pattern_search: PASSED **");
        else
            $display("** approximate_pattern_search: FAILED **");
        $finish;
    end

endmodule
